// File: sv/alkv_pkg.sv
package alkv_pkg;

   // Store geometry
   localparam int STORE_WORDS     = 4096;
   localparam int ADDR_W          = $clog2(STORE_WORDS);
   localparam int CNT_W           = ADDR_W + 1;
   localparam int MAX_VALUE_BYTES = 256;
   localparam int LEN_W           = 9;
   localparam int WORDS_W         = 7;

   localparam logic [31:0] SIGNATURE = 32'hFACE_BEEF;
   localparam logic [31:0] ERASED    = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_ERASE = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_DATA  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_BAD_SEQ   = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   // Memory port request from the sequencer
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [31:0]       wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // One result item towards the output register
   typedef struct packed {
      status_type  status;
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
   } rsp_item_type;

   // Data words needed for a value of len bytes
   function automatic logic [WORDS_W-1:0] ceil_words(input logic [LEN_W-1:0] len);
      logic [LEN_W:0] sum;
      sum = {1'b0, len} + (LEN_W+1)'(3);
      return WORDS_W'(sum >> 2);
   endfunction

   // Keep the cnt high bytes of a word, zero the rest
   function automatic logic [31:0] tail_mask(input logic [31:0] w, input logic [2:0] cnt);
      logic [31:0] r;
      unique case (cnt)
         3'd1:    r = {w[31:24], 24'd0};
         3'd2:    r = {w[31:16], 16'd0};
         3'd3:    r = {w[31:8], 8'd0};
         default: r = w;
      endcase
      return r;
   endfunction

endpackage

// File: sv/alkv_store.sv
module alkv_store
   import alkv_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [31:0] rd_data
);

   logic [31:0] store_ff [STORE_WORDS];
   logic [31:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Registered read port, holds while no read is issued
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= store_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/alkv_rsp_reg.sv
module alkv_rsp_reg
   import alkv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type item,
   output logic         free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // Slot is free when empty or being taken this cycle
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (push) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload until a new request is loaded
   always_ff @(posedge clock) begin
      if (push) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, item_ff.count, item_ff.word, item_ff.status};
   assign rsp_tlast  = item_ff.last;

endmodule

// File: sv/alkv_seq.sv
module alkv_seq
   import alkv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cmd_type          req_cmd,
   input  logic [31:0]      req_key,
   input  logic [LEN_W-1:0] req_length,
   input  logic [31:0]      req_data_word,
   output mem_req_type      mem_req,
   input  logic [31:0]      mem_data,
   input  logic             out_free,
   output logic             out_push,
   output rsp_item_type     out_item
);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_SIG0 = 11'b000_0000_0010,
      S_SIG1 = 11'b000_0000_0100,
      S_HCHK = 11'b000_0000_1000,
      S_HDR0 = 11'b000_0001_0000,
      S_HDR1 = 11'b000_0010_0000,
      S_DWR  = 11'b000_0100_0000,
      S_WKEY = 11'b000_1000_0000,
      S_WLEN = 11'b001_0000_0000,
      S_WADV = 11'b010_0000_0000,
      S_DRD  = 11'b100_0000_0000
   } state_type;

   // Output emission reuses the idle code space via a flag
   state_type          state_ff, state_in;
   logic               emit_ff, emit_in;
   logic               stream_ff, stream_in;
   logic [CNT_W-1:0]   hw_ff, hw_in;
   logic               open_ff, open_in;
   logic [WORDS_W-1:0] words_left_ff, words_left_in;
   cmd_type            cmd_ff, cmd_in;
   logic [31:0]        key_ff, key_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [31:0]        dw_ff, dw_in;
   status_type         status_ff, status_in;
   logic [CNT_W-1:0]   p_ff, p_in;
   logic               found_ff, found_in;
   logic               match_ff, match_in;
   logic [CNT_W-1:0]   hit_ff, hit_in;
   logic [LEN_W-1:0]   hit_len_ff, hit_len_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   rptr_ff, rptr_in;

   // Shared address adder
   logic [CNT_W-1:0]   add_a;
   logic [WORDS_W:0]   add_b;
   logic [CNT_W:0]     add_sum;
   logic [CNT_W-1:0]   p_next;
   logic               walk_more;
   logic [LEN_W-1:0]   n_bytes;
   logic [2:0]         cnt;
   logic               accept;

   always_comb begin
      if (state_ff == S_WADV) begin
         add_a = p_ff;
         add_b = (WORDS_W+1)'(2) + (WORDS_W+1)'(ceil_words(mem_data[LEN_W-1:0]));
      end else begin
         add_a = hw_ff;
         add_b = (WORDS_W+1)'(2) + (WORDS_W+1)'(ceil_words(len_ff));
      end
      add_sum = (CNT_W+1)'(add_a) + (CNT_W+1)'(add_b);
   end

   assign p_next    = (add_sum > (CNT_W+1)'(STORE_WORDS)) ? CNT_W'(STORE_WORDS)
                                                          : add_sum[CNT_W-1:0];
   assign walk_more = ((CNT_W+1)'(p_ff) + (CNT_W+1)'(1)) < (CNT_W+1)'(hw_ff);
   assign n_bytes   = (hit_len_ff < len_ff) ? hit_len_ff : len_ff;
   assign cnt       = (rem_ff >= LEN_W'(4)) ? 3'd4 : rem_ff[2:0];

   assign req_ready = (state_ff == S_IDLE) && !emit_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      emit_in       = emit_ff;
      stream_in     = stream_ff;
      hw_in         = hw_ff;
      open_in       = open_ff;
      words_left_in = words_left_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      dw_in         = dw_ff;
      status_in     = status_ff;
      p_in          = p_ff;
      found_in      = found_ff;
      match_in      = match_ff;
      hit_in        = hit_ff;
      hit_len_in    = hit_len_ff;
      rem_in        = rem_ff;
      rptr_in       = rptr_ff;
      mem_req       = '0;
      out_push      = 1'b0;
      out_item      = '{status: status_ff, word: 32'd0, count: 3'd0, last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            if (emit_ff) begin
               // Hand one result to the output register
               if (stream_ff) begin
                  out_item.status = ST_OK;
                  out_item.word   = tail_mask(mem_data, cnt);
                  out_item.count  = cnt;
                  out_item.last   = (rem_ff <= LEN_W'(4));
               end
               if (out_free) begin
                  out_push = 1'b1;
                  emit_in  = 1'b0;
                  if (stream_ff && (rem_ff > LEN_W'(4))) begin
                     rem_in   = rem_ff - LEN_W'(cnt);
                     rptr_in  = rptr_ff + CNT_W'(1);
                     state_in = S_DRD;
                  end
               end
            end else if (accept) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               len_in    = req_length;
               dw_in     = req_data_word;
               stream_in = 1'b0;
               status_in = ST_OK;
               priority if (req_cmd == CMD_ERASE) begin
                  open_in       = 1'b0;
                  words_left_in = '0;
                  state_in      = S_SIG0;
               end else if (req_cmd == CMD_DATA) begin
                  if (!open_ff || (hw_ff >= CNT_W'(STORE_WORDS))) begin
                     status_in = ST_BAD_SEQ;
                     emit_in   = 1'b1;
                  end else begin
                     state_in = S_DWR;
                  end
               end else if (open_ff) begin
                  status_in = ST_BAD_SEQ;
                  emit_in   = 1'b1;
               end else if (req_cmd == CMD_BEGIN) begin
                  if (req_length > LEN_W'(MAX_VALUE_BYTES)) begin
                     status_in = ST_TOO_LONG;
                     emit_in   = 1'b1;
                  end else if (hw_ff == '0) begin
                     state_in = S_SIG0;
                  end else begin
                     state_in = S_HCHK;
                  end
               end else begin
                  // Read: signature present exactly when the log holds words
                  if (hw_ff == '0) begin
                     status_in = ST_NOT_FOUND;
                     emit_in   = 1'b1;
                  end else begin
                     p_in     = CNT_W'(2);
                     found_in = 1'b0;
                     state_in = S_WKEY;
                  end
               end
            end
         end
         S_SIG0: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = SIGNATURE;
            state_in      = S_SIG1;
         end
         S_SIG1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ADDR_W'(1);
            mem_req.wdata = 32'd0;
            hw_in         = CNT_W'(2);
            if (cmd_ff == CMD_BEGIN) begin
               state_in = S_HCHK;
            end else begin
               emit_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_HCHK: begin
            if (add_sum > (CNT_W+1)'(STORE_WORDS)) begin
               status_in = ST_FULL;
               emit_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_HDR0;
            end
         end
         S_HDR0: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hw_ff[ADDR_W-1:0];
            mem_req.wdata = key_ff;
            hw_in         = hw_ff + CNT_W'(1);
            state_in      = S_HDR1;
         end
         S_HDR1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hw_ff[ADDR_W-1:0];
            mem_req.wdata = 32'(len_ff);
            hw_in         = hw_ff + CNT_W'(1);
            words_left_in = ceil_words(len_ff);
            open_in       = (ceil_words(len_ff) != '0);
            emit_in       = 1'b1;
            state_in      = S_IDLE;
         end
         S_DWR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hw_ff[ADDR_W-1:0];
            mem_req.wdata = dw_ff;
            hw_in         = hw_ff + CNT_W'(1);
            words_left_in = words_left_ff - WORDS_W'(1);
            if (words_left_ff == WORDS_W'(1)) begin
               open_in = 1'b0;
            end
            emit_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_WKEY: begin
            if (walk_more) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = p_ff[ADDR_W-1:0];
               state_in      = S_WLEN;
            end else if (!found_ff) begin
               status_in = ST_NOT_FOUND;
               emit_in   = 1'b1;
               state_in  = S_IDLE;
            end else if (n_bytes == '0) begin
               emit_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               rem_in   = n_bytes;
               rptr_in  = hit_ff + CNT_W'(2);
               state_in = S_DRD;
            end
         end
         S_WLEN: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ADDR_W'(p_ff + CNT_W'(1));
            match_in      = (mem_data == key_ff);
            state_in      = S_WADV;
         end
         S_WADV: begin
            // Newest match wins, so later hits overwrite
            if (match_ff) begin
               found_in   = 1'b1;
               hit_in     = p_ff;
               hit_len_in = mem_data[LEN_W-1:0];
            end
            p_in     = p_next;
            state_in = S_WKEY;
         end
         S_DRD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = rptr_ff[ADDR_W-1:0];
            stream_in     = 1'b1;
            emit_in       = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         emit_ff       <= 1'b0;
         stream_ff     <= 1'b0;
         hw_ff         <= '0;
         open_ff       <= 1'b0;
         words_left_ff <= '0;
      end else begin
         state_ff      <= state_in;
         emit_ff       <= emit_in;
         stream_ff     <= stream_in;
         hw_ff         <= hw_in;
         open_ff       <= open_in;
         words_left_ff <= words_left_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      len_ff     <= len_in;
      dw_ff      <= dw_in;
      status_ff  <= status_in;
      p_ff       <= p_in;
      found_ff   <= found_in;
      match_ff   <= match_in;
      hit_ff     <= hit_in;
      hit_len_ff <= hit_len_in;
      rem_ff     <= rem_in;
      rptr_ff    <= rptr_in;
   end

endmodule

// File: sv/append_log_key_value_store.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser cmd, tdata key, length, data_word
// rsp      out  rsp_tvalid/rsp_tready  tdata status, word_out, byte_count; tlast
//
// Erase writes the signature and a zero word; a data word writes one word; begin
// write may write the signature, checks space, then writes key and length; read
// walks each record header through the single read port (key, length, advance),
// then loads one status or reads and loads each value word. Reset clears the log
// high-water mark, not the memory: words above it are never read, so need no sweep.
// A stalled rsp holds the sequencer; req is taken again once the last result loads.
module append_log_key_value_store
   import alkv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] key, [40:32] length, [72:41] data_word, [79:73] zero
   input  logic [79:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [34:3] word_out, [37:35] byte_count, [39:38] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   mem_req_type  mem_req;
   logic [31:0]  mem_data;
   logic         out_free;
   logic         out_push;
   rsp_item_type out_item;

   alkv_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_cmd       (cmd_type'(req_tuser)),
      .req_key       (req_tdata[31:0]),
      .req_length    (req_tdata[40:32]),
      .req_data_word (req_tdata[72:41]),
      .mem_req       (mem_req),
      .mem_data      (mem_data),
      .out_free      (out_free),
      .out_push      (out_push),
      .out_item      (out_item)
   );

   alkv_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_data)
   );

   alkv_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .push       (out_push),
      .item       (out_item),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/tb_append_log_key_value_store.sv
module tb_append_log_key_value_store
   import alkv_pkg::*;
();

   // One request as queued for the driver
   typedef struct {
      cmd_type          cmd;
      logic [31:0]      key;
      logic [LEN_W-1:0] length;
      logic [31:0]      data;
      bit               drain;
   } log_req_type;

   // One reply as predicted
   typedef struct {
      status_type  status;
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
   } log_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   append_log_key_value_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   log_req_type   pending_req[$];
   log_reply_type replies_due[$];
   int            mismatches = 0;
   logic          req_taken = 1'b0;

   // Shadow copy of the log and the write cursor
   logic [31:0]        log_image [STORE_WORDS];
   longint             next_data = 0;
   logic [WORDS_W-1:0] words_owed = '0;
   bit                 rec_open = 0;

   logic [31:0] key_pool [8];

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] image_word(input longint a);
      return (a < STORE_WORDS) ? log_image[a] : ERASED;
   endfunction

   // Address of the header after the record at p, clamped to the store end
   function automatic longint skip_record(input longint p);
      longint len;
      longint n;
      len = image_word(p + 1);
      n = p + 2 + ((len + 3) >> 2);
      return (n > STORE_WORDS) ? STORE_WORDS : n;
   endfunction

   function automatic void wipe_log();
      for (int a = 0; a < STORE_WORDS; a++) log_image[a] = ERASED;
      log_image[0] = SIGNATURE;
      log_image[1] = '0;
   endfunction

   function automatic void push_reply(input status_type st, input logic [31:0] w,
                                      input logic [2:0] c, input logic l);
      log_reply_type r;
      r.status = st;
      r.word   = w;
      r.count  = c;
      r.last   = l;
      replies_due.push_back(r);
   endfunction

   // Apply one accepted request to the shadow log and queue its replies
   function automatic void apply_to_log(input cmd_type cmd, input logic [31:0] key,
                                        input logic [LEN_W-1:0] len,
                                        input logic [31:0] word);
      longint     p;
      longint     hit;
      longint     n;
      longint     i;
      longint     w;
      longint     cnt;
      logic [31:0] d;
      bit         found;
      if (cmd == CMD_ERASE) begin
         wipe_log();
         rec_open   = 0;
         words_owed = '0;
         next_data  = 0;
         push_reply(ST_OK, '0, '0, 1'b1);
      end else if (cmd == CMD_DATA) begin
         if (!rec_open || next_data >= STORE_WORDS) begin
            push_reply(ST_BAD_SEQ, '0, '0, 1'b1);
         end else begin
            log_image[next_data] = word;
            next_data++;
            words_owed = words_owed - 1'b1;
            if (words_owed == '0) rec_open = 0;
            push_reply(ST_OK, '0, '0, 1'b1);
         end
      end else if (rec_open) begin
         push_reply(ST_BAD_SEQ, '0, '0, 1'b1);
      end else if (cmd == CMD_BEGIN) begin
         if (len > MAX_VALUE_BYTES) begin
            push_reply(ST_TOO_LONG, '0, '0, 1'b1);
         end else begin
            // a missing signature forces an erase even when the record will not fit
            if (log_image[0] != SIGNATURE) wipe_log();
            p = skip_record(0);
            while (p + 1 < STORE_WORDS && log_image[p + 1] != ERASED) p = skip_record(p);
            w = (longint'(len) + 3) >> 2;
            if (p + 2 + w > STORE_WORDS) begin
               push_reply(ST_FULL, '0, '0, 1'b1);
            end else begin
               log_image[p]     = key;
               log_image[p + 1] = 32'(len);
               next_data  = p + 2;
               words_owed = WORDS_W'(w);
               rec_open   = (w != 0);
               push_reply(ST_OK, '0, '0, 1'b1);
            end
         end
      end else begin
         // read: the newest matching header wins, the signature record is skipped
         found = 0;
         hit   = 0;
         if (log_image[0] == SIGNATURE) begin
            p = skip_record(0);
            while (p + 1 < STORE_WORDS && log_image[p + 1] != ERASED) begin
               if (log_image[p] == key) begin
                  found = 1;
                  hit   = p;
               end
               p = skip_record(p);
            end
         end
         if (!found) begin
            push_reply(ST_NOT_FOUND, '0, '0, 1'b1);
         end else begin
            n = image_word(hit + 1);
            if (n > len) n = len;
            if (n > MAX_VALUE_BYTES) n = MAX_VALUE_BYTES;
            if (n == 0) begin
               push_reply(ST_OK, '0, '0, 1'b1);
            end else begin
               for (i = 0; i < n; i += 4) begin
                  d   = image_word(hit + 2 + (i >> 2));
                  cnt = (n - i > 4) ? 4 : n - i;
                  if (cnt < 4) d = d & ~(32'hFFFF_FFFF >> (8 * cnt));
                  push_reply(ST_OK, d, 3'(cnt), (i + 4 >= n));
               end
            end
         end
      end
   endfunction

   task automatic add_req(input cmd_type cmd, input logic [31:0] key,
                          input logic [LEN_W-1:0] len, input logic [31:0] data,
                          input bit drain = 0);
      log_req_type r;
      r.cmd    = cmd;
      r.key    = key;
      r.length = len;
      r.data   = data;
      r.drain  = drain;
      pending_req.push_back(r);
   endtask

   // Begin a record and send nwords data words for it
   task automatic add_record(input logic [31:0] key, input logic [LEN_W-1:0] len,
                             input int nwords);
      add_req(CMD_BEGIN, key, len, $urandom());
      for (int k = 0; k < nwords; k++)
         add_req(CMD_DATA, $urandom(), LEN_W'($urandom_range(0, 511)), $urandom());
   endtask

   // Request driver: hold until taken, then advance or idle
   bit req_bursty = 1;
   int req_gap = 0;
   always @(negedge clock) begin : feed
      log_req_type head;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_req.size() == 0 ||
                      (pending_req[0].drain && replies_due.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else if (req_bursty && pending_req.size() >= 50 &&
                      $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(1, 18) - 1;
            req_tvalid <= 1'b0;
         end else begin
            head = pending_req.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= head.cmd;
            req_tdata  <= {7'd0, head.data, head.length, head.key};
         end
         if ($urandom_range(0, 63) == 0) req_bursty = !req_bursty;
      end
   end

   // Reply side back-pressure
   bit rsp_bursty = 0;
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (rsp_bursty && pending_req.size() >= 50 && $urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) rsp_bursty = !rsp_bursty;
   end

   // Monitor: check replies against the oldest prediction, then predict new requests
   always @(posedge clock) begin : watch
      log_reply_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected reply: status %0d word %h count %0d last %b",
                           rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[37:35], rsp_tlast);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_tdata[2:0] !== want.status || rsp_tdata[34:3] !== want.word ||
                   rsp_tdata[37:35] !== want.count || rsp_tlast !== want.last) begin
                  if (mismatches < 10)
                     $display("reply mismatch: expected %0d/%h/%0d/%b got %0d/%h/%0d/%b",
                              want.status, want.word, want.count, want.last,
                              rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[37:35], rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_to_log(cmd_type'(req_tuser), req_tdata[31:0], req_tdata[40:32],
                         req_tdata[72:41]);
      end
   end

   initial begin
      int          base;
      int          pick;
      int          len;
      int          words;
      for (int a = 0; a < STORE_WORDS; a++) log_image[a] = ERASED;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = SIGNATURE;
      for (int k = 3; k < 8; k++) key_pool[k] = $urandom();

      // directed: no signature, sequencing errors, extremes of length and key
      add_req(CMD_READ, key_pool[3], 9'd4, 32'd0);
      add_req(CMD_DATA, 32'd0, 9'd0, 32'hA5A5_A5A5);
      add_req(CMD_BEGIN, key_pool[3], 9'd5, 32'd0);
      add_req(CMD_READ, key_pool[3], 9'd8, 32'd0);
      add_req(CMD_BEGIN, key_pool[4], 9'd4, 32'd0);
      add_req(CMD_DATA, 32'd0, 9'd0, 32'hFFFF_FFFF);
      add_req(CMD_DATA, 32'd0, 9'd0, 32'h0000_0000);
      add_req(CMD_DATA, 32'd0, 9'd0, 32'h1234_5678);
      add_req(CMD_READ, key_pool[3], 9'd511, 32'd0);
      add_req(CMD_READ, key_pool[3], 9'd3, 32'd0);
      add_req(CMD_READ, key_pool[3], 9'd0, 32'd0);
      add_req(CMD_BEGIN, key_pool[1], 9'd0, 32'd0);
      add_req(CMD_READ, key_pool[1], 9'd256, 32'd0);
      add_req(CMD_BEGIN, key_pool[4], 9'd257, 32'd0);
      add_req(CMD_BEGIN, key_pool[4], 9'd511, 32'd0);
      add_req(CMD_READ, key_pool[2], 9'd8, 32'd0);
      add_req(CMD_READ, key_pool[5], 9'd8, 32'd0);
      // abandon an open record by erasing
      add_req(CMD_BEGIN, key_pool[0], 9'd256, 32'd0);
      add_req(CMD_DATA, 32'd0, 9'd0, 32'hFFFF_FFFF);
      add_req(CMD_ERASE, 32'hFFFF_FFFF, 9'd511, 32'hFFFF_FFFF);
      add_req(CMD_READ, key_pool[0], 9'd256, 32'd0);
      add_req(CMD_READ, key_pool[3], 9'd256, 32'd0);

      // random: mostly whole records and reads, some truncation and noise
      base = pending_req.size();
      while (pending_req.size() < base + 75) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            case ($urandom_range(0, 9))
               0:       len = 256;
               1:       len = $urandom_range(0, 511);
               default: len = $urandom_range(0, 40);
            endcase
            words = (len + 3) / 4;
            if ($urandom_range(0, 7) == 0) words = $urandom_range(0, words);
            add_record(key_pool[$urandom_range(0, 7)], LEN_W'(len), words);
         end else if (pick < 75) begin
            add_req(CMD_READ, ($urandom_range(0, 7) == 0) ? $urandom() :
                    key_pool[$urandom_range(0, 7)], LEN_W'($urandom_range(0, 511)),
                    $urandom());
         end else if (pick < 80) begin
            add_req(CMD_ERASE, $urandom(), LEN_W'($urandom_range(0, 511)), $urandom());
         end else begin
            add_req(cmd_type'($urandom_range(0, 3)), $urandom(),
                    LEN_W'($urandom_range(0, 511)), $urandom());
         end
      end

      // quiet tail on a fresh log; hold off until every reply is in first
      add_req(CMD_ERASE, 32'd0, 9'd0, 32'd0, 1);
      for (int k = 0; k < 4; k++) begin
         len = $urandom_range(0, 24);
         add_record(key_pool[$urandom_range(3, 7)], LEN_W'(len), (len + 3) / 4);
         add_req(CMD_READ, key_pool[$urandom_range(3, 7)], LEN_W'($urandom_range(0, 511)),
                 32'd0);
      end

      // hold reset, then release it on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do @(posedge clock);
      while (pending_req.size() != 0 || req_tvalid || replies_due.size() != 0);
      repeat (300) @(posedge clock);

      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
